// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the tokenizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define XSAT_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset
`define XSAT_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/xsat_pkg.sv -----
package xsat_pkg;

  // Parser phases
  localparam logic [3:0] PhStart     = 4'd0;
  localparam logic [3:0] PhSlash     = 4'd1;
  localparam logic [3:0] PhElem      = 4'd2;
  localparam logic [3:0] PhBetween   = 4'd3;
  localparam logic [3:0] PhName      = 4'd4;
  localparam logic [3:0] PhAfterName = 4'd5;
  localparam logic [3:0] PhAfterEq   = 4'd6;
  localparam logic [3:0] PhQuoted    = 4'd7;
  localparam logic [3:0] PhUnquoted  = 4'd8;
  localparam logic [3:0] PhDone      = 4'd9;

  // Byte roles
  localparam logic [1:0] RoleNone  = 2'd0;
  localparam logic [1:0] RoleName  = 2'd1;
  localparam logic [1:0] RoleValue = 2'd2;

  // Commit events
  localparam logic [1:0] CommitNone    = 2'd0;
  localparam logic [1:0] CommitNoValue = 2'd1;
  localparam logic [1:0] CommitValue   = 2'd2;
  localparam logic [1:0] CommitDrop    = 2'd3;

  localparam logic [8:0] AttrCap   = 9'd256;
  localparam logic [8:0] CountMax  = 9'h1FF;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChHigh    = 8'h80;

  localparam int OutWidth = 16;

  // Tokenizer state
  typedef struct packed {
    logic [3:0] phase;
    logic       quote_single;
    logic [8:0] count;
  } tok_state_t;

  // One result item
  typedef struct packed {
    logic       stopped;
    logic [8:0] attribute_count;
    logic [1:0] commit_after;
    logic [1:0] commit_before;
    logic [1:0] byte_role;
  } tok_result_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_name_byte(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F) || (b == 8'h3A) ||
           (b == 8'h2D) || (b == 8'h2E) || (b >= ChHigh);
  endfunction

  // Counter that sticks at all ones
  function automatic logic [8:0] sat_inc(logic [8:0] c);
    return (c == CountMax) ? c : c + 9'd1;
  endfunction

  // Phase taken where a new attribute name is looked for
  function automatic logic [3:0] seek_next(logic [7:0] b, logic [8:0] cnt,
                                           logic [8:0] lim);
    logic [3:0] ph;
    if (cnt >= lim)                        ph = PhDone;
    else if (is_space(b))                  ph = PhBetween;
    else if (b == ChGt || b == ChSlash)    ph = PhDone;
    else if (is_name_byte(b))              ph = PhName;
    else                                   ph = PhBetween;
    return ph;
  endfunction

endpackage

// ----- rtl/xml_start_tag_attribute_tokenizer_core.sv -----
// XML start-tag attribute tokenizer. Feed the raw bytes of one start tag, one
// byte per request on the slave side, with tlast on the final byte; each byte
// yields one result on the master side giving the byte's role (name, value or
// neither), commit events before and after the byte, the running attribute
// count and a stopped flag. A byte is taken every clock while the master side
// keeps tready high: one input register, the tokenizer step logic and one
// output register, so throughput is one byte per cycle. State returns to its
// reset values after each tlast byte. max_attributes is loaded through
// cfg_we/cfg_data and should only be changed while no request is in flight.
`include "assert_macros.svh"

module xml_start_tag_attribute_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,   // max_attributes
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // tag_byte
  input  logic        s_tlast,    // is_last
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // byte_role, commit_before, commit_after,
                                  // attribute_count, stopped
  output logic        m_tlast     // last_out
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  advance;
  logic [8:0]            max_attributes;
  xsat_pkg::tok_state_t  state;
  xsat_pkg::tok_state_t  state_next;
  xsat_pkg::tok_result_t step_res;
  xsat_pkg::tok_result_t out_res;
  logic                  out_valid;
  logic                  out_last;

  // Input stage moves on whenever the output register is free or drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attributes <= xsat_pkg::AttrCap;
    end else if (cfg_we) begin
      max_attributes <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  xsat_step u_step (
    .cur            (state),
    .tag_byte       (in_byte),
    .is_last        (in_last),
    .max_attributes (max_attributes),
    .nxt            (state_next),
    .res            (step_res)
  );

  // Tokenizer state updates as the byte leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= xsat_pkg::PhStart;
      state.quote_single <= 1'b0;
      state.count        <= 9'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res  <= step_res;
      out_last <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = xsat_pkg::OutWidth'(out_res);
  assign m_tlast  = out_last;

  // Checks
  `XSAT_ASSERT_NEXT(a_last_clears, clk, rst, advance && in_last,
                    state.phase == xsat_pkg::PhStart && state.count == 9'd0)
  `XSAT_ASSERT_NOW(a_count_cap, clk, rst, m_tvalid,
                   out_res.attribute_count <= xsat_pkg::AttrCap)
  `XSAT_ASSERT_NOW(a_last_stops, clk, rst, m_tvalid && m_tlast, out_res.stopped)
  `XSAT_ASSERT_NOW(a_drop_on_last, clk, rst,
                   m_tvalid && out_res.commit_after == xsat_pkg::CommitDrop, m_tlast)

endmodule

// ----- rtl/xsat_step.sv -----
// Per-byte tokenizer step: current state and byte in, next state and result out.
module xsat_step (
  input  xsat_pkg::tok_state_t  cur,
  input  logic [7:0]            tag_byte,
  input  logic                  is_last,
  input  logic [8:0]            max_attributes,
  output xsat_pkg::tok_state_t  nxt,
  output xsat_pkg::tok_result_t res
);

  logic [8:0] lim;
  logic [8:0] c;
  logic [3:0] ph;
  logic       qs;
  logic [1:0] role;
  logic [1:0] pre_commit;
  logic [1:0] after;
  logic [7:0] qchar;
  logic       term;

  assign lim   = (max_attributes > xsat_pkg::AttrCap) ? xsat_pkg::AttrCap : max_attributes;
  assign qchar = cur.quote_single ? xsat_pkg::ChSquote : xsat_pkg::ChDquote;
  assign term  = (tag_byte == xsat_pkg::ChGt) || (tag_byte == xsat_pkg::ChSlash);

  // Phase transition and role of this byte
  always_comb begin
    c          = cur.count;
    ph         = cur.phase;
    qs         = cur.quote_single;
    role       = xsat_pkg::RoleNone;
    pre_commit = xsat_pkg::CommitNone;
    after      = xsat_pkg::CommitNone;
    case (cur.phase)
      xsat_pkg::PhStart: begin
        ph = xsat_pkg::PhSlash;
      end
      xsat_pkg::PhSlash: begin
        if (tag_byte == xsat_pkg::ChSlash || xsat_pkg::is_name_byte(tag_byte)) begin
          ph = xsat_pkg::PhElem;
        end else begin
          ph = xsat_pkg::seek_next(tag_byte, c, lim);
        end
      end
      xsat_pkg::PhElem: begin
        if (!xsat_pkg::is_name_byte(tag_byte)) begin
          ph = xsat_pkg::seek_next(tag_byte, c, lim);
        end
      end
      xsat_pkg::PhBetween: begin
        ph = xsat_pkg::seek_next(tag_byte, c, lim);
      end
      xsat_pkg::PhName, xsat_pkg::PhAfterName: begin
        if (cur.phase == xsat_pkg::PhName && xsat_pkg::is_name_byte(tag_byte)) begin
          ph = xsat_pkg::PhName;
        end else if (xsat_pkg::is_space(tag_byte)) begin
          ph = xsat_pkg::PhAfterName;
        end else if (tag_byte == xsat_pkg::ChEq) begin
          ph = xsat_pkg::PhAfterEq;
        end else begin
          pre_commit = xsat_pkg::CommitNoValue;
          c          = xsat_pkg::sat_inc(c);
          ph         = xsat_pkg::seek_next(tag_byte, c, lim);
        end
      end
      xsat_pkg::PhAfterEq: begin
        if (xsat_pkg::is_space(tag_byte)) begin
          ph = xsat_pkg::PhAfterEq;
        end else if (tag_byte == xsat_pkg::ChDquote || tag_byte == xsat_pkg::ChSquote) begin
          qs = (tag_byte == xsat_pkg::ChSquote);
          ph = xsat_pkg::PhQuoted;
        end else if (!term) begin
          ph = xsat_pkg::PhUnquoted;
        end else begin
          // empty unquoted value closed by a terminator
          pre_commit = xsat_pkg::CommitValue;
          c          = xsat_pkg::sat_inc(c);
          ph         = xsat_pkg::seek_next(tag_byte, c, lim);
        end
      end
      xsat_pkg::PhQuoted: begin
        if (tag_byte == qchar) begin
          after = xsat_pkg::CommitValue;
          c     = xsat_pkg::sat_inc(c);
          ph    = (c >= lim) ? xsat_pkg::PhDone : xsat_pkg::PhBetween;
        end
      end
      xsat_pkg::PhUnquoted: begin
        if (xsat_pkg::is_space(tag_byte) || term) begin
          pre_commit = xsat_pkg::CommitValue;
          c          = xsat_pkg::sat_inc(c);
          ph         = xsat_pkg::seek_next(tag_byte, c, lim);
        end
      end
      default: begin
        ph = xsat_pkg::PhDone;
      end
    endcase

    // Role follows the phase the byte lands in
    case (ph)
      xsat_pkg::PhName: begin
        role = xsat_pkg::RoleName;
      end
      xsat_pkg::PhUnquoted: begin
        role = xsat_pkg::RoleValue;
      end
      xsat_pkg::PhQuoted: begin
        role = (cur.phase == xsat_pkg::PhQuoted) ? xsat_pkg::RoleValue : xsat_pkg::RoleNone;
      end
      default: begin
        role = xsat_pkg::RoleNone;
      end
    endcase

    // End of data closes whatever is pending
    if (is_last) begin
      case (ph)
        xsat_pkg::PhName, xsat_pkg::PhAfterName: begin
          after = xsat_pkg::CommitNoValue;
          c     = xsat_pkg::sat_inc(c);
        end
        xsat_pkg::PhAfterEq: begin
          after = xsat_pkg::CommitDrop;
        end
        xsat_pkg::PhQuoted, xsat_pkg::PhUnquoted: begin
          after = xsat_pkg::CommitValue;
          c     = xsat_pkg::sat_inc(c);
        end
        default: begin
          after = after;
        end
      endcase
    end
  end

  // Result and next state
  always_comb begin
    res.byte_role       = role;
    res.commit_before   = pre_commit;
    res.commit_after    = after;
    res.attribute_count = c;
    res.stopped         = (ph == xsat_pkg::PhDone) || is_last;
    if (is_last) begin
      nxt.phase        = xsat_pkg::PhStart;
      nxt.quote_single = 1'b0;
      nxt.count        = 9'd0;
    end else begin
      nxt.phase        = ph;
      nxt.quote_single = qs;
      nxt.count        = c;
    end
  end

endmodule
